// ===== sv/cfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants shared by the checksum frame deframer modules.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REG_HDR_FIRST  = 1'b0;
  localparam logic REG_HDR_SECOND = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_LENGTH   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_ADDR = 3'd2,
    PH_CMD  = 3'd3,
    PH_LEN  = 3'd4,
    PH_DATA = 3'd5,
    PH_SUM  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_SINGLE = 2'd1,
    BK_EMIT   = 2'd2
  } back_state_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] length;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } pl_wr_t;

endpackage

// ===== sv/cfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_front
// Frame parser: takes received bytes, tracks the frame phase and checksum,
// writes payload bytes and queues one job per finished or failed frame.
// ----------------------------------------------------------------------------
module cfd_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic [7:0]      header_first,
  input  logic [7:0]      header_second,
  input  logic            drain_busy,
  input  logic            q_full,
  output logic            push,
  output cfd_pkg::job_t   push_job,
  output cfd_pkg::pl_wr_t wr
);
  import cfd_pkg::*;

  localparam int LIMIT = (MAX_PAYLOAD > STORE_DEPTH) ? STORE_DEPTH : MAX_PAYLOAD;

  phase_t     phase, phase_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] held_length, held_length_next;
  logic [6:0] count, count_next;
  logic [7:0] running_sum, running_sum_next;

  logic       accept;
  logic [7:0] sum_add;
  logic [6:0] count_inc;

  assign accept    = in_valid && in_ready;
  assign sum_add   = running_sum + in_byte;
  assign count_inc = count + 7'd1;

  always_comb begin
    unique case (phase)
      PH_LEN, PH_SUM: in_ready = !q_full;
      PH_DATA:        in_ready = !drain_busy;
      default:        in_ready = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HDR0: if (in_byte == header_first) phase_next = PH_HDR1;
        PH_HDR1: begin
          if (in_byte == header_second) begin
            phase_next = PH_ADDR;
          end else if (in_byte != header_first) begin
            phase_next = PH_HDR0;
          end
        end
        PH_ADDR: phase_next = PH_CMD;
        PH_CMD:  phase_next = PH_LEN;
        PH_LEN: begin
          if (in_byte > 8'(LIMIT)) begin
            phase_next = PH_HDR0;
          end else if (in_byte == 8'd0) begin
            phase_next = PH_SUM;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: if ({1'b0, count_inc} >= held_length) phase_next = PH_SUM;
        PH_SUM:  phase_next = PH_HDR0;
        default: phase_next = PH_HDR0;
      endcase
    end
  end

  // outputs and datapath
  always_comb begin
    held_address_next = held_address;
    held_command_next = held_command;
    held_length_next  = held_length;
    count_next        = count;
    running_sum_next  = running_sum;
    push              = 1'b0;
    push_job.status   = ST_GOOD;
    push_job.address  = held_address;
    push_job.command  = held_command;
    push_job.length   = held_length;
    wr.en             = 1'b0;
    wr.addr           = count[IDX_W-1:0];
    wr.data           = in_byte;
    if (accept) begin
      unique case (phase)
        PH_HDR0: if (in_byte == header_first) running_sum_next = in_byte;
        PH_HDR1: begin
          if (in_byte == header_second) begin
            running_sum_next = sum_add;
          end else if (in_byte == header_first) begin
            running_sum_next = in_byte;
          end else begin
            running_sum_next = 8'd0;
            count_next       = 7'd0;
          end
        end
        PH_ADDR: begin
          held_address_next = in_byte;
          running_sum_next  = sum_add;
        end
        PH_CMD: begin
          held_command_next = in_byte;
          running_sum_next  = sum_add;
        end
        PH_LEN: begin
          held_length_next = in_byte;
          count_next       = 7'd0;
          if (in_byte > 8'(LIMIT)) begin
            push             = 1'b1;
            push_job.status  = ST_LENGTH;
            push_job.length  = in_byte;
            running_sum_next = 8'd0;
          end else begin
            running_sum_next = sum_add;
          end
        end
        PH_DATA: begin
          wr.en            = 1'b1;
          count_next       = count_inc;
          running_sum_next = sum_add;
        end
        PH_SUM: begin
          push             = 1'b1;
          push_job.status  = (in_byte != running_sum) ? ST_CHECKSUM : ST_GOOD;
          running_sum_next = 8'd0;
          count_next       = 7'd0;
        end
        default: begin
          running_sum_next = 8'd0;
          count_next       = 7'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      held_address <= 8'd0;
      held_command <= 8'd0;
      held_length  <= 8'd0;
      count        <= 7'd0;
      running_sum  <= 8'd0;
    end else begin
      phase        <= phase_next;
      held_address <= held_address_next;
      held_command <= held_command_next;
      held_length  <= held_length_next;
      count        <= count_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

// ===== sv/cfd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_queue
// Short job queue between the frame parser and the result emitter.
// ----------------------------------------------------------------------------
module cfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cfd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output cfd_pkg::job_t head_job
);
  import cfd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   fill;
  logic             do_push, do_pop;

  assign full       = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= wptr + PTR_W'(1);
      if (do_pop)  rptr <= rptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   fill <= fill + (PTR_W+1)'(1);
        2'b01:   fill <= fill - (PTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== sv/cfd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_back
// Result emitter: holds the payload memory, takes jobs from the queue and
// sends one status word or a run of payload words into the output register.
// ----------------------------------------------------------------------------
module cfd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  cfd_pkg::job_t   q_job,
  output logic            q_pop,
  input  cfd_pkg::pl_wr_t wr,
  output logic            busy,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [39:0]     m_tdata,  // address, command, length, payload, index, pad
  output logic [2:0]      m_tuser,  // status[1:0], has_payload
  output logic            m_tlast
);
  import cfd_pkg::*;

  back_state_t      state, state_next;
  job_t             job;
  logic [IDX_W-1:0] idx, idx_next;
  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             out_free, is_last, head_has, load, load_has;

  assign out_free = !m_tvalid || m_tready;
  assign is_last  = (({2'b00, idx} + 8'd1) == job.length);
  assign head_has = (q_job.status == ST_GOOD) && (q_job.length != 8'd0);
  assign busy     = (state != BK_IDLE);

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (q_valid) state_next = head_has ? BK_EMIT : BK_SINGLE;
      BK_SINGLE: if (out_free) state_next = BK_IDLE;
      BK_EMIT:   if (out_free && is_last) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    idx_next = idx;
    load     = 1'b0;
    load_has = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop    = q_valid;
        rd_en    = q_valid && head_has;
        idx_next = '0;
      end
      BK_SINGLE: load = out_free;
      BK_EMIT: begin
        load     = out_free;
        load_has = 1'b1;
        if (out_free && !is_last) begin
          rd_en    = 1'b1;
          rd_addr  = idx + IDX_W'(1);
          idx_next = idx + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) job <= q_job;
    if (load) begin
      m_tdata[7:0]   <= job.address;
      m_tdata[15:8]  <= job.command;
      m_tdata[23:16] <= job.length;
      m_tdata[31:24] <= load_has ? rd_data : 8'd0;
      m_tdata[37:32] <= load_has ? idx : '0;
      m_tdata[39:38] <= 2'b00;
      m_tuser        <= {load_has, job.status};
      m_tlast        <= load_has ? is_last : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/checksum_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_deframer
// Parses header/address/command/length/payload/checksum frames from a byte
// stream and emits status words or runs of payload words.
// ----------------------------------------------------------------------------
// The input takes one byte per cycle, except that a payload byte waits while
// any earlier result is still queued or being loaded into the output register,
// so the payload memory is never overwritten under a run being sent, and the
// length or checksum byte waits while the two-entry job queue is full. The
// back end first takes a job from the queue, then loads one word per cycle when
// the sink is ready: N words for a good frame with N payload bytes, read from a
// registered memory, and one word for an error frame or an empty frame.
module checksum_frame_deframer #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // frame_address, frame_command, frame_length,
                                 // payload_byte, byte_index[5:0], pad
  output logic [2:0]  m_tuser,   // status[1:0], has_payload
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfd_pkg::*;

  logic [7:0] header_first, header_second;
  logic       cfg_write;
  logic       q_full, q_valid, q_pop, push, back_busy, drain_busy;
  job_t       push_job, q_job;
  pl_wr_t     wr;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {24'd0, (paddr[2] == REG_HDR_SECOND) ? header_second : header_first};

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= 8'h57;
      header_second <= 8'hAB;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_HDR_FIRST:  header_first  <= pwdata[7:0];
        REG_HDR_SECOND: header_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign drain_busy = back_busy || q_valid;

  cfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_byte      (s_tdata),
    .header_first (header_first),
    .header_second(header_second),
    .drain_busy   (drain_busy),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job),
    .wr           (wr)
  );

  cfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_job  (q_job)
  );

  cfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .wr      (wr),
    .busy    (back_busy),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

// ===== sv/cfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level assertions for the checksum frame deframer, bound to the top.
// ----------------------------------------------------------------------------
module cfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import cfd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_single_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> m_tlast && (m_tdata[37:32] == 6'd0)
      && (m_tdata[31:24] == 8'd0))
    else $error("word without payload is not a lone last word");

  a_error_no_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] != ST_GOOD) |-> !m_tuser[2])
    else $error("error word carries payload");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |->
      (m_tlast == (({2'b00, m_tdata[37:32]} + 8'd1) == m_tdata[23:16])))
    else $error("last mark does not match payload index and length");

endmodule

bind checksum_frame_deframer cfd_checker u_cfd_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
